// ===== src/whm_pkg.sv =====
// Package for the word multiply-xor hash block: hash constants, queue command
// type and the xor-shift helper. No dependencies.
`timescale 1ns / 1ps

package whm_pkg;

   localparam logic [63:0] SEED_CONST = 64'h243F6A8885A308D3;
   localparam logic [63:0] MUL_CONST  = 64'h9E3779B97F4A7C15;
   localparam logic [63:0] FMIX_MUL_A = 64'hFF51AFD7ED558CCD;
   localparam logic [63:0] FMIX_MUL_B = 64'hC4CEB9FE1A85EC53;
   localparam int unsigned FMIX_SHIFT = 33;

   // default depth of the queue between front and back
   localparam int unsigned QUEUE_DEPTH_DEF = 2;

   // one classified beat, as handed from front to back
   typedef struct packed {
      logic        first;
      logic        last;
      logic        mix;
      logic [63:0] seed;
      logic [63:0] word;
   } cmd_type;

   function automatic logic [63:0] xor_shift(input logic [63:0] v);
      xor_shift = v ^ (v >> FMIX_SHIFT);
   endfunction

endpackage

// ===== src/whm_front.sv =====
// Front part: classifies an input beat into a queue command (seed, masked
// word, mix and last flags). Depends on whm_pkg.
`timescale 1ns / 1ps

module whm_front (
   input  logic            req_first,
   input  logic            req_last,
   input  logic [63:0]     req_message_length,
   input  logic [63:0]     req_data_word,
   input  logic [3:0]      req_byte_count,
   output whm_pkg::cmd_type cmd
);

   logic [63:0] byte_mask;

   // byte i is kept when i is below the count; counts of eight and up keep all
   always_comb begin
      for (int i = 0; i < 8; i++) begin
         byte_mask[i*8 +: 8] = (4'(i) < req_byte_count) ? 8'hFF : 8'h00;
      end
   end

   always_comb begin
      cmd.first = req_first;
      cmd.last  = req_last;
      cmd.mix   = (req_byte_count != 4'd0);
      cmd.seed  = whm_pkg::SEED_CONST ^ req_message_length;
      cmd.word  = req_data_word & byte_mask;
   end

endmodule

// ===== src/whm_queue.sv =====
// Small command queue between front and back parts.
// Depends on whm_pkg for the command type.
`timescale 1ns / 1ps

module whm_queue #(
   parameter int unsigned DEPTH = whm_pkg::QUEUE_DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  whm_pkg::cmd_type push_cmd,
   output logic             full,
   input  logic             pop,
   output logic             not_empty,
   output whm_pkg::cmd_type head
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   whm_pkg::cmd_type   entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = entry_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ===== src/whm_mul.sv =====
// Sequential 64 x 64 -> 64 (low half) multiplier, one 32 x 32 partial
// product per cycle: low x low, then two cross terms. Depends on nothing but the clock.
`timescale 1ns / 1ps

module whm_mul (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] op_a,
   input  logic [63:0] op_b,
   output logic        done,
   output logic [63:0] product
);

   localparam logic [1:0] STEP_LO    = 2'd0;
   localparam logic [1:0] STEP_CROSS = 2'd1;
   localparam logic [1:0] STEP_FINAL = 2'd2;

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [1:0]  step_ff, step_in;
   logic [63:0] a_ff, a_in;
   logic [63:0] b_ff, b_in;
   logic [63:0] acc_ff, acc_in;
   logic [31:0] a_part, b_part;
   logic [63:0] pp;

   // low x low, then the two cross terms that land in the upper half
   always_comb begin
      case (step_ff)
         STEP_LO: begin
            a_part = a_ff[31:0];
            b_part = b_ff[31:0];
         end
         STEP_CROSS: begin
            a_part = a_ff[31:0];
            b_part = b_ff[63:32];
         end
         default: begin
            a_part = a_ff[63:32];
            b_part = b_ff[31:0];
         end
      endcase
   end

   assign pp = a_part * b_part;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = STEP_LO;
         a_in    = op_a;
         b_in    = op_b;
      end else if (busy_ff) begin
         if (step_ff == STEP_LO) begin
            acc_in = pp;
         end else begin
            acc_in = acc_ff + {pp[31:0], 32'd0};
         end
         if (step_ff == STEP_FINAL) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= STEP_LO;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

// ===== src/whm_back.sv =====
// Back part: owns the running hash, mixes queued words, runs the fmix64
// finalizer and holds the result register. Depends on whm_pkg and whm_mul.
`timescale 1ns / 1ps

module whm_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   input  whm_pkg::cmd_type cmd,
   output logic             cmd_pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [63:0]      rsp_hash_value
);

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_MIX  = 5'b00010,
      ST_FMA  = 5'b00100,
      ST_FMB  = 5'b01000,
      ST_OUT  = 5'b10000
   } state_type;

   state_type   state_ff, state_in;
   logic [63:0] hash_ff, hash_in;
   logic        last_ff, last_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [63:0] rsp_hash_ff, rsp_hash_in;
   logic [63:0] seeded;
   logic        mul_start, mul_done;
   logic [63:0] mul_a, mul_b, mul_product;

   whm_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .done    (mul_done),
      .product (mul_product)
   );

   assign seeded = cmd.first ? cmd.seed : hash_ff;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      hash_in      = hash_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_hash_in  = rsp_hash_ff;
      cmd_pop      = 1'b0;
      mul_start    = 1'b0;
      mul_a        = whm_pkg::xor_shift(mul_product);
      mul_b        = whm_pkg::FMIX_MUL_A;
      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               hash_in = seeded;
               last_in = cmd.last;
               if (cmd.mix) begin
                  mul_start = 1'b1;
                  mul_a     = seeded ^ cmd.word;
                  mul_b     = whm_pkg::MUL_CONST;
                  state_in  = ST_MIX;
               end else if (cmd.last) begin
                  mul_start = 1'b1;
                  mul_a     = whm_pkg::xor_shift(seeded);
                  state_in  = ST_FMA;
               end
            end
         end
         ST_MIX: begin
            if (mul_done) begin
               hash_in = mul_product;
               if (last_ff) begin
                  mul_start = 1'b1;
                  state_in  = ST_FMA;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_FMA: begin
            if (mul_done) begin
               mul_start = 1'b1;
               mul_b     = whm_pkg::FMIX_MUL_B;
               state_in  = ST_FMB;
            end
         end
         ST_FMB: begin
            if (mul_done) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            // load the result once the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_hash_in  = whm_pkg::xor_shift(mul_product);
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         hash_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         hash_ff      <= hash_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      last_ff     <= last_in;
      rsp_hash_ff <= rsp_hash_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hash_value = rsp_hash_ff;

endmodule

// ===== src/word_multiply_xor_hash64.sv =====
// Top level of the streaming 64-bit multiply-xor hash with fmix64 finalizer.
// Depends on whm_pkg, whm_front, whm_queue and whm_back.
//
//   Channel | Direction | Handshake          | Payload
//   req_    | in        | req_valid/req_stall | first, last, message_length,
//           |           |                     | data_word, byte_count
//   rsp_    | out       | rsp_valid/rsp_stall | hash_value
//
// A word with non-zero byte count is popped by the back part and then runs
// through the shared 32 x 32 multiplier until its done flag is raised; a last
// word adds two more multiplies and an output load.
// The multiplier is the bottleneck; the queue lets the front take beats ahead.
// Reset is synchronous and clears the queue, sequencer, hash and rsp_valid.
// A stalled result holds the back part in its output state; the queue fills
// and then req_stall rises.
`timescale 1ns / 1ps

module word_multiply_xor_hash64 #(
   parameter int unsigned QUEUE_DEPTH = whm_pkg::QUEUE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_first,
   input  logic        req_last,
   input  logic [63:0] req_message_length,
   input  logic [63:0] req_data_word,
   input  logic [3:0]  req_byte_count,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_hash_value
);

   whm_pkg::cmd_type front_cmd;
   whm_pkg::cmd_type head_cmd;
   logic             q_full, q_not_empty, q_pop;

   whm_front u_front (
      .req_first          (req_first),
      .req_last           (req_last),
      .req_message_length (req_message_length),
      .req_data_word      (req_data_word),
      .req_byte_count     (req_byte_count),
      .cmd                (front_cmd)
   );

   whm_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_valid),
      .push_cmd  (front_cmd),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .head      (head_cmd)
   );

   assign req_stall = q_full;

   whm_back u_back (
      .clock          (clock),
      .reset          (reset),
      .cmd_valid      (q_not_empty),
      .cmd            (head_cmd),
      .cmd_pop        (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_hash_value (rsp_hash_value)
   );

endmodule
